/* hw/rtl/mqlb_pkg.sv */
// ----------------------------------------------------------------------------
// mqlb_pkg
// Types and codes shared by the multi-queue linked buffer.
// ----------------------------------------------------------------------------
package mqlb_pkg;

   localparam int QIDX_W = 7;
   localparam int KEY_W  = 32;

   typedef logic [QIDX_W-1:0]       qidx_type;
   typedef logic signed [KEY_W-1:0] key_type;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

/* hw/rtl/multi_queue_linked_buffer_top.sv */
// ----------------------------------------------------------------------------
// multi_queue_linked_buffer_top
// A request word that is taken passes through the stage 1, stage 2 and result
// registers before its result word shows on the response port.
// Throughput: one word per cycle unless rsp_stall holds the pipeline; a word whose
// queue is held by one of the two words ahead waits until they have left, as does
// an enqueue that needs a node still being returned by a dequeue ahead of it.
// Reset clears control state only; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module multi_queue_linked_buffer_top #(
   parameter int NUM_QUEUES = 128,
   parameter int NODE_COUNT = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mqlb_pkg::op_type       req_operation,
   input  mqlb_pkg::qidx_type     req_queue_index,
   input  mqlb_pkg::key_type      req_key,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mqlb_pkg::status_type   rsp_status,
   output mqlb_pkg::key_type      rsp_dequeued_key
);
   import mqlb_pkg::*;

   localparam int QSPAN  = 2 ** QIDX_W;
   localparam int QDEPTH = (NUM_QUEUES < QSPAN) ? NUM_QUEUES : QSPAN;
   localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int NAW    = $clog2(NODE_COUNT);
   localparam int CW     = $clog2(NODE_COUNT + 1);

   typedef logic [NAW-1:0] node_type;
   typedef logic [CW-1:0]  count_type;

   typedef struct packed {
      node_type head;
      node_type tail;
   } qent_type;

   // memories
   key_type  node_keys [NODE_COUNT];
   node_type node_next [NODE_COUNT];
   node_type free_mem  [NODE_COUNT];
   qent_type qmem      [QDEPTH];

   // control state
   logic [QDEPTH-1:0] nonempty_ff;
   count_type         free_count_ff, free_count_in;
   count_type         wm_ff, wm_in;
   count_type         avail_ff, avail_in;
   node_type          rd_ptr_ff, rd_ptr_in;
   node_type          wr_ptr_ff, wr_ptr_in;
   logic              s1_valid_ff, s2_valid_ff, rsp_valid_ff;

   // stage 1
   op_type     s1_op_ff;
   qidx_type   s1_q_ff;
   key_type    s1_key_ff;
   logic       s1_ok_ff;
   logic       s1_wasne_ff;
   logic       s1_from_fifo_ff;
   node_type   s1_wm_node_ff;
   status_type s1_status_ff;
   qent_type   qmem_rd_ff;
   node_type   fifo_rd_ff;
   node_type   s1_node;

   // stage 2
   op_type     s2_op_ff;
   qidx_type   s2_q_ff;
   key_type    s2_key_ff;
   logic       s2_ok_ff;
   logic       s2_wasne_ff;
   node_type   s2_node_ff;
   qent_type   s2_qent_ff;
   status_type s2_status_ff;
   key_type    keys_rd_ff;
   node_type   next_rd_ff;

   // result register
   status_type rsp_status_ff;
   key_type    rsp_key_ff;

   logic       q_ok, is_enq, use_wm, enq_ok, deq_ok;
   logic       hazard, free_wait, accept, pop, take_wm;
   logic       en1, en2, rsp_en, s2_go, push;
   logic       s2_enq_ok, s2_deq_ok, s2_last;
   logic [QAW-1:0] q_addr, s2_qaddr;

   // accept side
   assign q_ok    = int'(req_queue_index) < NUM_QUEUES;
   assign q_addr  = req_queue_index[QAW-1:0];
   assign is_enq  = (req_operation == OP_ENQUEUE);
   assign use_wm  = (wm_ff != CW'(NODE_COUNT));
   assign enq_ok  = is_enq && q_ok && (free_count_ff != '0);
   assign deq_ok  = !is_enq && q_ok && nonempty_ff[q_addr];

   assign hazard    = (s1_valid_ff && (s1_q_ff == req_queue_index)) ||
                      (s2_valid_ff && (s2_q_ff == req_queue_index));
   assign free_wait = enq_ok && !use_wm && (avail_ff == '0);

   assign rsp_en = !rsp_valid_ff || !rsp_stall;
   assign en2    = !s2_valid_ff || rsp_en;
   assign en1    = !s1_valid_ff || en2;

   assign req_stall = !en1 || hazard || free_wait;
   assign accept    = req_valid && !req_stall;
   assign pop       = accept && enq_ok && !use_wm;
   assign take_wm   = accept && enq_ok && use_wm;

   // stage 1 and 2 decode
   assign s1_node   = s1_from_fifo_ff ? fifo_rd_ff : s1_wm_node_ff;
   assign s2_go     = s2_valid_ff && rsp_en;
   assign s2_enq_ok = s2_ok_ff && (s2_op_ff == OP_ENQUEUE);
   assign s2_deq_ok = s2_ok_ff && (s2_op_ff == OP_DEQUEUE);
   assign s2_last   = (s2_qent_ff.head == s2_qent_ff.tail);
   assign s2_qaddr  = s2_q_ff[QAW-1:0];
   assign push      = s2_go && s2_deq_ok;

   always_comb begin
      free_count_in = free_count_ff;
      if (accept && enq_ok) begin
         free_count_in = free_count_ff - 1'b1;
      end else if (accept && deq_ok) begin
         free_count_in = free_count_ff + 1'b1;
      end
      wm_in    = take_wm ? wm_ff + 1'b1 : wm_ff;
      avail_in = avail_ff + CW'(push) - CW'(pop);
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == NAW'(NODE_COUNT - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == NAW'(NODE_COUNT - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         free_count_ff <= CW'(NODE_COUNT);
         wm_ff         <= '0;
         avail_ff      <= '0;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         nonempty_ff   <= '0;
      end else begin
         if (en1) begin
            s1_valid_ff <= accept;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rsp_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         free_count_ff <= free_count_in;
         wm_ff         <= wm_in;
         avail_ff      <= avail_in;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         if (s2_go && s2_enq_ok) begin
            nonempty_ff[s2_qaddr] <= 1'b1;
         end else if (s2_go && s2_deq_ok && s2_last) begin
            nonempty_ff[s2_qaddr] <= 1'b0;
         end
      end
   end

   // pipeline payload and registered memory reads
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_op_ff        <= req_operation;
         s1_q_ff         <= req_queue_index;
         s1_key_ff       <= req_key;
         s1_ok_ff        <= is_enq ? enq_ok : deq_ok;
         s1_wasne_ff     <= q_ok && nonempty_ff[q_addr];
         s1_from_fifo_ff <= !use_wm;
         s1_wm_node_ff   <= wm_ff[NAW-1:0];
         if (is_enq) begin
            s1_status_ff <= enq_ok ? ST_OK : ST_FULL;
         end else begin
            s1_status_ff <= deq_ok ? ST_OK : ST_EMPTY;
         end
         qmem_rd_ff <= qmem[q_addr];
         fifo_rd_ff <= free_mem[rd_ptr_ff];
      end
      if (en2) begin
         s2_op_ff     <= s1_op_ff;
         s2_q_ff      <= s1_q_ff;
         s2_key_ff    <= s1_key_ff;
         s2_ok_ff     <= s1_ok_ff;
         s2_wasne_ff  <= s1_wasne_ff;
         s2_node_ff   <= s1_node;
         s2_qent_ff   <= qmem_rd_ff;
         s2_status_ff <= s1_status_ff;
         keys_rd_ff   <= node_keys[qmem_rd_ff.head];
         next_rd_ff   <= node_next[qmem_rd_ff.head];
      end
      if (s2_go) begin
         rsp_status_ff <= s2_status_ff;
         rsp_key_ff    <= s2_deq_ok ? keys_rd_ff : '0;
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (s2_go && s2_enq_ok) begin
         node_keys[s2_node_ff] <= s2_key_ff;
         if (s2_wasne_ff) begin
            node_next[s2_qent_ff.tail] <= s2_node_ff;
            qmem[s2_qaddr] <= '{head: s2_qent_ff.head, tail: s2_node_ff};
         end else begin
            qmem[s2_qaddr] <= '{head: s2_node_ff, tail: s2_node_ff};
         end
      end else if (s2_go && s2_deq_ok && !s2_last) begin
         qmem[s2_qaddr] <= '{head: next_rd_ff, tail: s2_qent_ff.tail};
      end
      if (push) begin
         free_mem[wr_ptr_ff] <= s2_qent_ff.head;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_dequeued_key = rsp_key_ff;

`ifndef SYNTHESIS
   a_no_queue_overlap: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |-> (s1_q_ff != s2_q_ff))
      else $error("same queue in both pipeline stages");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> (avail_ff != '0))
      else $error("free node popped from empty return list");

   a_free_accounting: assert property (@(posedge clock) disable iff (reset)
      (CW'(NODE_COUNT) - wm_ff + avail_ff) <= free_count_ff)
      else $error("stored free nodes exceed free count");
`endif

endmodule
